// ===== rtl/smd_pkg.sv =====
// ----------------------------------------------------------------------------
// smd_pkg: shared types and constants of the separable max dilation unit
// Register map codes, reset values, control struct and the pixel max helper.
// ----------------------------------------------------------------------------
package smd_pkg;

  // register indexes on the configuration port (byte address = 4 * index)
  localparam int unsigned CfgAddrW = 4;
  localparam logic [1:0] RegRadius = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  // register reset values
  localparam logic [3:0] RadiusReset = 4'd1;
  localparam logic [8:0] WidthReset  = 9'd256;
  localparam logic [8:0] HeightReset = 9'd256;

  // cycles that the derived frame figures need after a register write
  localparam logic [1:0] SettleCycles = 2'd3;

  // control from the register block to the stream side
  typedef struct packed {
    logic busy;     // derived figures not yet settled
    logic restart;  // valid register write: restart the frame
  } cfg_ctl_t;

  function automatic logic [7:0] max_pix(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/smd_cfg.sv =====
// ----------------------------------------------------------------------------
// smd_cfg: configuration registers
// APB register file, clamped effective values and the derived frame figures.
// ----------------------------------------------------------------------------
module smd_cfg #(
  parameter int MAX_RADIUS = 8,
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int RADW = $clog2(MAX_RADIUS + 1),
  localparam int WW   = $clog2(MAX_WIDTH + 1),
  localparam int HW   = $clog2(MAX_HEIGHT + 1),
  localparam int SW   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [smd_pkg::CfgAddrW-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output smd_pkg::cfg_ctl_t           ctl_o,
  output logic [RADW-1:0]             r_eff_o,
  output logic [WW-1:0]               w_eff_o,
  output logic [HW-1:0]               h_eff_o,
  output logic [SW-1:0]               dly_o,
  output logic [SW-1:0]               end_o
);

  logic [3:0]      radius_q;
  logic [8:0]      width_q;
  logic [8:0]      height_q;
  logic [1:0]      settle_q;
  logic [1:0]      idx;
  logic            wr_en;
  logic            wr_hit;
  logic [RADW-1:0] r_eff_q;
  logic [WW-1:0]   w_eff_q;
  logic [HW-1:0]   h_eff_q;
  logic [SW-1:0]   dly_q;
  logic [SW-1:0]   npix_q;
  logic [SW-1:0]   end_q;

  assign idx    = paddr_i[3:2];
  assign wr_en  = psel_i && penable_i && pwrite_i;
  assign wr_hit = wr_en && (idx == smd_pkg::RegRadius || idx == smd_pkg::RegWidth ||
                            idx == smd_pkg::RegHeight);

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= smd_pkg::RadiusReset;
      width_q  <= smd_pkg::WidthReset;
      height_q <= smd_pkg::HeightReset;
    end else if (wr_en) begin
      unique case (idx)
        smd_pkg::RegRadius: radius_q <= pwdata_i[3:0];
        smd_pkg::RegWidth:  width_q  <= pwdata_i[8:0];
        smd_pkg::RegHeight: height_q <= pwdata_i[8:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      smd_pkg::RegRadius: prdata_o = {28'd0, radius_q};
      smd_pkg::RegWidth:  prdata_o = {23'd0, width_q};
      smd_pkg::RegHeight: prdata_o = {23'd0, height_q};
      default:            prdata_o = 32'd0;
    endcase
  end

  // hold the stream side off while the derived figures settle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= smd_pkg::SettleCycles;
    end else if (wr_hit) begin
      settle_q <= smd_pkg::SettleCycles;
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  // clamp to the supported range
  always_ff @(posedge clk_i) begin
    r_eff_q <= (32'(radius_q) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(radius_q);
    if (width_q == 9'd0) begin
      w_eff_q <= WW'(1);
    end else begin
      w_eff_q <= (32'(width_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_q);
    end
    if (height_q == 9'd0) begin
      h_eff_q <= HW'(1);
    end else begin
      h_eff_q <= (32'(height_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_q);
    end
  end

  // output lag in items, frame size and the step of the final output
  always_ff @(posedge clk_i) begin
    dly_q  <= SW'(r_eff_q) * SW'(w_eff_q) + SW'(r_eff_q);
    npix_q <= SW'(w_eff_q) * SW'(h_eff_q);
    end_q  <= dly_q + npix_q - SW'(1);
  end

  assign ctl_o.busy    = (settle_q != 2'd0);
  assign ctl_o.restart = wr_hit;
  assign r_eff_o       = r_eff_q;
  assign w_eff_o       = w_eff_q;
  assign h_eff_o       = h_eff_q;
  assign dly_o         = dly_q;
  assign end_o         = end_q;

endmodule

// ===== rtl/smd_hmax.sv =====
// ----------------------------------------------------------------------------
// smd_hmax: horizontal running maximum
// Tap line of recent words; masks taps outside the centre's row and reduces
// them through a two-stage max tree.
// ----------------------------------------------------------------------------
module smd_hmax #(
  parameter int MAX_RADIUS = 8,
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int RADW = $clog2(MAX_RADIUS + 1),
  localparam int CW   = $clog2(MAX_WIDTH),
  localparam int RW   = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            restart_i,
  input  logic [RADW-1:0] r_eff_i,
  input  logic            tok_valid_i,
  input  logic [7:0]      tok_pix_i,
  input  logic [RW-1:0]   tok_row_i,
  input  logic [CW-1:0]   tok_col_i,
  input  logic            tok_emit_i,
  input  logic            tok_last_i,
  output logic            h_valid_o,
  output logic [7:0]      h_pix_o,
  output logic [RW-1:0]   h_row_o,
  output logic [CW-1:0]   h_col_o,
  output logic            h_cok_o,
  output logic            h_emit_o,
  output logic            h_last_o
);

  localparam int NT  = 2 * MAX_RADIUS + 1;
  localparam int TIW = $clog2(NT);
  localparam int NG  = (NT + 3) / 4;

  logic [7:0]    tap_pix_q [NT];
  logic [RW-1:0] tap_row_q [NT];
  logic [CW-1:0] tap_col_q [NT];
  logic [NT-1:0] tap_ok_q;
  logic [7:0]    tap_pix_d [NT];
  logic [RW-1:0] tap_row_d [NT];
  logic [CW-1:0] tap_col_d [NT];
  logic [NT-1:0] tap_ok_d;
  logic [TIW-1:0] ctr_idx;
  logic [7:0]    msk [NT];

  logic          a_valid_q, a_cok_q, a_emit_q, a_last_q;
  logic [7:0]    a_m_q [NT];
  logic [RW-1:0] a_row_q;
  logic [CW-1:0] a_col_q;
  logic          b_valid_q, b_cok_q, b_emit_q, b_last_q;
  logic [7:0]    b_g_q [NG];
  logic [7:0]    grp [NG];
  logic [RW-1:0] b_row_q;
  logic [CW-1:0] b_col_q;
  logic          c_valid_q, c_cok_q, c_emit_q, c_last_q;
  logic [7:0]    c_pix_q;
  logic [7:0]    fin;
  logic [RW-1:0] c_row_q;
  logic [CW-1:0] c_col_q;

  // shift the incoming word into the tap line
  always_comb begin
    for (int k = 0; k < NT; k++) begin
      tap_pix_d[k] = tap_pix_q[k];
      tap_row_d[k] = tap_row_q[k];
      tap_col_d[k] = tap_col_q[k];
    end
    tap_ok_d = tap_ok_q;
    if (tok_valid_i) begin
      tap_pix_d[0] = tok_pix_i;
      tap_row_d[0] = tok_row_i;
      tap_col_d[0] = tok_col_i;
      tap_ok_d[0]  = 1'b1;
      for (int k = 1; k < NT; k++) begin
        tap_pix_d[k] = tap_pix_q[k-1];
        tap_row_d[k] = tap_row_q[k-1];
        tap_col_d[k] = tap_col_q[k-1];
        tap_ok_d[k]  = tap_ok_q[k-1];
      end
    end
  end

  // keep only taps inside the window and on the centre's row
  assign ctr_idx = TIW'(r_eff_i);
  always_comb begin
    for (int k = 0; k < NT; k++) begin
      msk[k] = (tap_ok_d[k] && tap_row_d[k] == tap_row_d[ctr_idx] &&
                k <= 2 * int'(r_eff_i)) ? tap_pix_d[k] : 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && tok_valid_i) begin
      for (int k = 0; k < NT; k++) begin
        tap_pix_q[k] <= tap_pix_d[k];
        tap_row_q[k] <= tap_row_d[k];
        tap_col_q[k] <= tap_col_d[k];
      end
    end
  end

  // drop the tap line at frame end or register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_ok_q <= '0;
    end else if (restart_i) begin
      tap_ok_q <= '0;
    end else if (adv_i && tok_valid_i) begin
      tap_ok_q <= tok_last_i ? '0 : tap_ok_d;
    end
  end

  // stage A: masked taps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= tok_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < NT; k++) a_m_q[k] <= msk[k];
      a_row_q  <= tap_row_d[ctr_idx];
      a_col_q  <= tap_col_d[ctr_idx];
      a_cok_q  <= tap_ok_d[ctr_idx];
      a_emit_q <= tok_emit_i;
      a_last_q <= tok_last_i;
    end
  end

  // stage B: max over groups of four taps
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp[g] = 8'd0;
      for (int k = 4 * g; k < 4 * g + 4; k++) begin
        if (k < NT) grp[g] = smd_pkg::max_pix(grp[g], a_m_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int g = 0; g < NG; g++) b_g_q[g] <= grp[g];
      b_row_q  <= a_row_q;
      b_col_q  <= a_col_q;
      b_cok_q  <= a_cok_q;
      b_emit_q <= a_emit_q;
      b_last_q <= a_last_q;
    end
  end

  // stage C: max over the groups
  always_comb begin
    fin = 8'd0;
    for (int g = 0; g < NG; g++) fin = smd_pkg::max_pix(fin, b_g_q[g]);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_pix_q  <= fin;
      c_row_q  <= b_row_q;
      c_col_q  <= b_col_q;
      c_cok_q  <= b_cok_q;
      c_emit_q <= b_emit_q;
      c_last_q <= b_last_q;
    end
  end

  assign h_valid_o = c_valid_q;
  assign h_pix_o   = c_pix_q;
  assign h_row_o   = c_row_q;
  assign h_col_o   = c_col_q;
  assign h_cok_o   = c_cok_q;
  assign h_emit_o  = c_emit_q;
  assign h_last_o  = c_last_q;

endmodule

// ===== rtl/smd_vmax.sv =====
// ----------------------------------------------------------------------------
// smd_vmax: vertical maximum
// Chain of line memories holding earlier rows' horizontal maxima, row mask,
// two-stage max tree and the output register.
// ----------------------------------------------------------------------------
module smd_vmax #(
  parameter int MAX_RADIUS = 8,
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int RADW = $clog2(MAX_RADIUS + 1),
  localparam int CW   = $clog2(MAX_WIDTH),
  localparam int RW   = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic [RADW-1:0] r_eff_i,
  input  logic            h_valid_i,
  input  logic [7:0]      h_pix_i,
  input  logic [RW-1:0]   h_row_i,
  input  logic [CW-1:0]   h_col_i,
  input  logic            h_cok_i,
  input  logic            h_emit_i,
  input  logic            h_last_i,
  output logic            out_valid_o,
  output logic [7:0]      out_pix_o,
  output logic            out_last_o
);

  localparam int NL = 2 * MAX_RADIUS;
  localparam int NT = NL + 1;
  localparam int NG = (NT + 3) / 4;

  logic [7:0]    rd_q [NL];
  logic [7:0]    wd   [NL];
  logic          wr_en, byp;
  logic          d_valid_q, d_cok_q, d_emit_q, d_last_q;
  logic [7:0]    d_pix_q;
  logic [RW-1:0] d_row_q;
  logic [CW-1:0] d_col_q;
  logic [7:0]    msk [NT];
  logic          e_valid_q, e_last_q;
  logic [7:0]    e_m_q [NT];
  logic [7:0]    grp [NG];
  logic          f_valid_q, f_last_q;
  logic [7:0]    f_g_q [NG];
  logic [7:0]    fin;
  logic          o_valid_q, o_last_q;
  logic [7:0]    o_pix_q;

  // each line takes the one above it; line 0 takes the new row
  always_comb begin
    wd[0] = d_pix_q;
    for (int k = 1; k < NL; k++) wd[k] = rd_q[k-1];
  end

  assign wr_en = adv_i && d_valid_q && d_cok_q;
  assign byp   = wr_en && (d_col_q == h_col_i);

  // line memories: write behind the read, forward when the column repeats
  for (genvar k = 0; k < NL; k++) begin : g_line
    logic [7:0] mem_q [MAX_WIDTH];
    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem_q[d_col_q] <= wd[k];
      end
      if (adv_i) begin
        rd_q[k] <= byp ? wd[k] : mem_q[h_col_i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (adv_i) begin
      d_valid_q <= h_valid_i;
      e_valid_q <= d_valid_q && d_emit_q;
      f_valid_q <= e_valid_q;
      o_valid_q <= f_valid_q;
    end
  end

  // stage D: line reads alongside the horizontal maximum
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_pix_q  <= h_pix_i;
      d_row_q  <= h_row_i;
      d_col_q  <= h_col_i;
      d_cok_q  <= h_cok_i;
      d_emit_q <= h_emit_i;
      d_last_q <= h_last_i;
    end
  end

  // stage E: keep rows inside the window and inside the frame
  always_comb begin
    msk[0] = d_pix_q;
    for (int k = 1; k < NT; k++) begin
      msk[k] = (k <= 2 * int'(r_eff_i) && int'(d_row_q) >= k) ? rd_q[k-1] : 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < NT; k++) e_m_q[k] <= msk[k];
      e_last_q <= d_last_q;
    end
  end

  // stage F: max over groups of four rows
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp[g] = 8'd0;
      for (int k = 4 * g; k < 4 * g + 4; k++) begin
        if (k < NT) grp[g] = smd_pkg::max_pix(grp[g], e_m_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int g = 0; g < NG; g++) f_g_q[g] <= grp[g];
      f_last_q <= e_last_q;
    end
  end

  // stage G: final max into the output register
  always_comb begin
    fin = 8'd0;
    for (int g = 0; g < NG; g++) fin = smd_pkg::max_pix(fin, f_g_q[g]);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      o_pix_q  <= fin;
      o_last_q <= f_last_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_pix_o   = o_pix_q;
  assign out_last_o  = o_last_q;

endmodule

// ===== rtl/separable_max_dilation_unit.sv =====
// ----------------------------------------------------------------------------
// separable_max_dilation_unit: grayscale dilation over a square window
// Raster stream in, per-pixel window maximum out, clipped at frame edges.
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+-------------------------------
//   s_axis   | in  | s_axis_tvalid/tready    | tdata: pixel_in, tuser: action
//   m_axis   | out | m_axis_tvalid/tready    | tdata: pixel_out, tlast
//   apb      | in  | psel/penable/pready     | radius, width, height
//
// One word per clock while the output is taken and the figures are settled;
// a word reaches the output register through the counter stage, three
// horizontal stages, the line memory read and three vertical stages. The
// first result of a frame leaves on the word r*width + r of that frame.
// All stages stall together when the output word is not taken. After reset
// and after each register write the input is held off while figures settle.
// ----------------------------------------------------------------------------
module separable_max_dilation_unit #(
  parameter int MAX_RADIUS = 8,
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] pixel_in
  input  logic                         s_axis_tuser,   // [0] action
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // [7:0] pixel_out
  output logic                         m_axis_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smd_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int RADW = $clog2(MAX_RADIUS + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1);
  localparam int SW   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

  smd_pkg::cfg_ctl_t ctl;
  logic [RADW-1:0] r_eff;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic [SW-1:0]   dly;
  logic [SW-1:0]   end_step;

  logic            adv, accept;
  logic [SW-1:0]   step_q;
  logic [RW-1:0]   row_q;
  logic [CW-1:0]   col_q;
  logic            s0_emit, s0_last, col_end;
  logic [7:0]      s0_pix;

  logic            s1_valid_q, s1_emit_q, s1_last_q;
  logic [7:0]      s1_pix_q;
  logic [RW-1:0]   s1_row_q;
  logic [CW-1:0]   s1_col_q;

  logic            h_valid, h_cok, h_emit, h_last;
  logic [7:0]      h_pix;
  logic [RW-1:0]   h_row;
  logic [CW-1:0]   h_col;

  assign pready = 1'b1;

  smd_cfg #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .ctl_o     (ctl),
    .r_eff_o   (r_eff),
    .w_eff_o   (w_eff),
    .h_eff_o   (h_eff),
    .dly_o     (dly),
    .end_o     (end_step)
  );

  // advance the whole pipeline unless the output word is stuck
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !ctl.busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // position of the incoming word and whether it releases a result
  assign s0_emit = (step_q >= dly);
  assign s0_last = (step_q == end_step);
  assign col_end = ((WW'(col_q) + WW'(1)) == w_eff);
  assign s0_pix  = (!s_axis_tuser && int'(row_q) < int'(h_eff)) ? s_axis_tdata : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
    end else if (ctl.restart) begin
      step_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
    end else if (accept) begin
      if (s0_last) begin
        step_q <= '0;
        row_q  <= '0;
        col_q  <= '0;
      end else begin
        step_q <= step_q + SW'(1);
        if (col_end) begin
          col_q <= '0;
          row_q <= row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  // stage 1: register the word with its position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pix_q  <= s0_pix;
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
      s1_emit_q <= s0_emit;
      s1_last_q <= s0_last;
    end
  end

  smd_hmax #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_hmax (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .restart_i   (ctl.restart),
    .r_eff_i     (r_eff),
    .tok_valid_i (s1_valid_q),
    .tok_pix_i   (s1_pix_q),
    .tok_row_i   (s1_row_q),
    .tok_col_i   (s1_col_q),
    .tok_emit_i  (s1_emit_q),
    .tok_last_i  (s1_last_q),
    .h_valid_o   (h_valid),
    .h_pix_o     (h_pix),
    .h_row_o     (h_row),
    .h_col_o     (h_col),
    .h_cok_o     (h_cok),
    .h_emit_o    (h_emit),
    .h_last_o    (h_last)
  );

  smd_vmax #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_vmax (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .r_eff_i     (r_eff),
    .h_valid_i   (h_valid),
    .h_pix_i     (h_pix),
    .h_row_i     (h_row),
    .h_col_i     (h_col),
    .h_cok_i     (h_cok),
    .h_emit_i    (h_emit),
    .h_last_i    (h_last),
    .out_valid_o (m_axis_tvalid),
    .out_pix_o   (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  // the final word of a frame always releases a result
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q |-> s1_emit_q)
    else $error("frame end word without a result");

  // a register write holds the input off in the next cycle
  a_write_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.restart |=> !s_axis_tready)
    else $error("input taken while frame figures settle");

  // a stuck output word stalls the input
  a_stall_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken during output stall");

  // the frame counters restart after the final word
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s0_last |=> step_q == '0 && row_q == '0 && col_q == '0)
    else $error("counters not cleared at frame end");
`endif

endmodule
